@@ src/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 decoder with whitespace skipping.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned MaxPush     = 3;
  localparam int unsigned PushW       = 2;
  localparam int unsigned OutDepthDef = 8;
  localparam int unsigned SInTdataW   = 8;
  localparam int unsigned MOutTdataW  = 16;

  // character classes beyond the sextet values
  localparam logic [7:0] ClsPad = 8'h40;
  localparam logic [7:0] ClsBad = 8'h80;
  localparam logic [7:0] ClsWs  = 8'h81;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_AFTER_PAD = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_data;
    logic             is_last;
    status_e          status;
  } res_t;

endpackage

@@ src/b64d_core.sv @@
// ----------------------------------------------------------------------------
// b64d_core
// Character classification, quartet state and byte extraction; gives up to
// three results for each accepted word.
// ----------------------------------------------------------------------------
module b64d_core (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      accept_i,
  input  logic [b64d_pkg::CharW-1:0]                char_i,
  input  logic                                      eot_i,
  output b64d_pkg::res_t [b64d_pkg::MaxPush-1:0]    res_o,
  output logic [b64d_pkg::PushW-1:0]                n_o
);
  import b64d_pkg::*;

  function automatic logic [7:0] classify(input logic [7:0] ch);
    logic [7:0] c;
    if (ch inside {[8'h41:8'h5A]})      c = ch - 8'h41;
    else if (ch inside {[8'h61:8'h7A]}) c = ch - 8'h61 + 8'd26;
    else if (ch inside {[8'h30:8'h39]}) c = ch - 8'h30 + 8'd52;
    else if (ch == 8'h2B)               c = 8'd62;
    else if (ch == 8'h2F)               c = 8'd63;
    else if (ch == 8'h3D)               c = ClsPad;
    else if (ch inside {8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B}) c = ClsWs;
    else                                c = ClsBad;
    return c;
  endfunction

  logic [1:0]  slot_q, slot_d;
  logic [17:0] held_q, held_d;
  logic        third_q, third_d;
  logic        done_q, done_d;
  logic        bad_q, bad_d;
  logic        after_q, after_d;

  logic [7:0]  cls;
  logic        is_pad;
  logic [5:0]  sextet;
  logic [23:0] quartet;
  status_e     st;

  always_comb begin
    slot_d  = slot_q;
    held_d  = held_q;
    third_d = third_q;
    done_d  = done_q;
    bad_d   = bad_q;
    after_d = after_q;
    res_o   = '0;
    n_o     = '0;
    cls     = classify(char_i);
    is_pad  = (cls == ClsPad);
    sextet  = is_pad ? 6'd0 : cls[5:0];
    quartet = {held_q, sextet};
    if (bad_q)             st = ST_BAD_CHAR;
    else if (slot_q != '0) st = ST_BAD_COUNT;
    else if (after_q)      st = ST_AFTER_PAD;
    else                   st = ST_OK;

    if (accept_i) begin
      if (eot_i) begin
        res_o[0].is_last = 1'b1;
        res_o[0].status  = st;
        n_o     = 2'd1;
        slot_d  = '0;
        held_d  = '0;
        third_d = 1'b0;
        done_d  = 1'b0;
        bad_d   = 1'b0;
        after_d = 1'b0;
      end else if (cls == ClsBad) begin
        bad_d = 1'b1;
      end else if (cls == ClsWs) begin
        // skipped
      end else if (done_q) begin
        after_d = 1'b1;
        slot_d  = slot_q + 2'd1;
      end else if (slot_q != 2'd3) begin
        held_d = {held_q[11:0], sextet};
        if (slot_q == 2'd2) begin
          third_d = is_pad;
        end
        slot_d = slot_q + 2'd1;
      end else begin
        res_o[0].data_byte = quartet[23:16];
        res_o[0].is_data   = 1'b1;
        n_o = 2'd1;
        if (third_q) begin
          done_d = 1'b1;
        end else begin
          res_o[1].data_byte = quartet[15:8];
          res_o[1].is_data   = 1'b1;
          n_o = 2'd2;
          if (is_pad) begin
            done_d = 1'b1;
          end else begin
            res_o[2].data_byte = quartet[7:0];
            res_o[2].is_data   = 1'b1;
            n_o = 2'd3;
          end
        end
        slot_d  = '0;
        held_d  = '0;
        third_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      held_q  <= '0;
      third_q <= 1'b0;
      done_q  <= 1'b0;
      bad_q   <= 1'b0;
      after_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      held_q  <= held_d;
      third_q <= third_d;
      done_q  <= done_d;
      bad_q   <= bad_d;
      after_q <= after_d;
    end
  end

endmodule

@@ src/base64_decoder_whitespace_skip.sv @@
// ----------------------------------------------------------------------------
// base64_decoder_whitespace_skip
// Streaming base64 decoder: one character per word in, decoded bytes and a
// closing status word out.
//
//   channel | dir | tdata                     | tuser   | tlast
//   s_axis  | in  | [7:0] character           | -       | end_of_text
//   m_axis  | out | [7:0] data_byte [9:8] st. | is_data | is_last
//
// One input word per cycle; each gives 0 to 3 result words to a small
// output queue of OutDepth words, drained one a cycle while the receiver
// is ready; input is held off while fewer than three entries are free.
// Reset clears the decoder state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module base64_decoder_whitespace_skip #(
  parameter int unsigned OutDepth = b64d_pkg::OutDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [b64d_pkg::SInTdataW-1:0]    s_axis_tdata,   // [7:0] character
  input  logic                              s_axis_tlast,   // end_of_text
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [b64d_pkg::MOutTdataW-1:0]   m_axis_tdata,   // [7:0] data_byte, [9:8] status
  output logic                              m_axis_tuser,   // is_data
  output logic                              m_axis_tlast    // is_last
);
  import b64d_pkg::*;

  localparam int unsigned PtrW     = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW     = $clog2(OutDepth + 1);
  localparam int unsigned MemDepth = 2 ** PtrW;

  logic                     accept;
  logic                     pop;
  res_t [MaxPush-1:0]       res;
  logic [PushW-1:0]         n_push;

  res_t                     mem_q [MemDepth];
  logic [PtrW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  res_t                     head;

  assign s_axis_tready = (cnt_q <= CntW'(OutDepth - MaxPush));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  b64d_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata[CharW-1:0]),
    .eot_i    (s_axis_tlast),
    .res_o    (res),
    .n_o      (n_push)
  );

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPush; k++) begin
      if (PushW'(k) < n_push) begin
        mem_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  assign head = mem_q[rd_ptr_q];

  assign m_axis_tdata = {{(MOutTdataW - ByteW - StatusW){1'b0}}, head.status, head.data_byte};
  assign m_axis_tuser = head.is_data;
  assign m_axis_tlast = head.is_last;

endmodule

@@ test/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// b64d_checker
// Watches both stream channels of the base64 decoder. Each input word that is
// accepted runs through a local decoder model, and the result words that the
// model expects are queued. Each output word that is accepted is compared
// field by field with the oldest queued word. The number of failures and the
// number of words still expected are passed to the testbench top.
// ----------------------------------------------------------------------------
module b64d_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [b64d_pkg::SInTdataW-1:0]  in_data_i,
  input  logic                            in_last_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [b64d_pkg::MOutTdataW-1:0] out_data_i,
  input  logic                            out_user_i,
  input  logic                            out_last_i,
  output int unsigned                     pending_o,
  output int unsigned                     fails_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  logic [1:0]  slot_pos;
  logic [17:0] held_sx;
  logic        third_pad;
  logic        pad_done;
  logic        bad_seen;
  logic        after_pad;
  res_t        expected_words[$];
  res_t        want;
  int unsigned n_mismatch;

  function automatic logic [7:0] char_class(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
    if (ch == "+") return 8'd62;
    if (ch == "/") return 8'd63;
    if (ch == "=") return ClsPad;
    if (ch == 8'h20 || ch == 8'h0C || ch == 8'h0A || ch == 8'h0D || ch == 8'h09 ||
        ch == 8'h0B) return ClsWs;
    return ClsBad;
  endfunction

  function automatic res_t data_word(input logic [7:0] b);
    res_t r;
    r.data_byte = b;
    r.is_data   = 1'b1;
    r.is_last   = 1'b0;
    r.status    = ST_OK;
    return r;
  endfunction

  task automatic clear_decoder();
    slot_pos  = '0;
    held_sx   = '0;
    third_pad = 1'b0;
    pad_done  = 1'b0;
    bad_seen  = 1'b0;
    after_pad = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic eot);
    logic [7:0]  cls;
    logic        is_pad;
    logic [5:0]  sx;
    logic [23:0] quad;
    res_t        r;
    if (eot) begin
      r.data_byte = '0;
      r.is_data   = 1'b0;
      r.is_last   = 1'b1;
      if (bad_seen)           r.status = ST_BAD_CHAR;
      else if (slot_pos != 0) r.status = ST_BAD_COUNT;
      else if (after_pad)     r.status = ST_AFTER_PAD;
      else                    r.status = ST_OK;
      expected_words.push_back(r);
      clear_decoder();
      return;
    end
    cls = char_class(ch);
    if (cls == ClsBad) begin
      bad_seen = 1'b1;
      return;
    end
    if (cls == ClsWs) return;
    is_pad = (cls == ClsPad);
    sx     = is_pad ? 6'd0 : cls[5:0];
    if (pad_done) begin
      after_pad = 1'b1;
      slot_pos  = slot_pos + 2'd1;
      return;
    end
    if (slot_pos != 2'd3) begin
      held_sx = {held_sx[11:0], sx};
      if (slot_pos == 2'd2) third_pad = is_pad;
      slot_pos = slot_pos + 2'd1;
      return;
    end
    quad = {held_sx, sx};
    expected_words.push_back(data_word(quad[23:16]));
    if (third_pad) begin
      pad_done = 1'b1;
    end else begin
      expected_words.push_back(data_word(quad[15:8]));
      if (is_pad) pad_done = 1'b1;
      else expected_words.push_back(data_word(quad[7:0]));
    end
    slot_pos  = '0;
    held_sx   = '0;
    third_pad = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
      expected_words.delete();
      n_mismatch = 0;
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      // outputs first: a result never stems from the word accepted at this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: unexpected word: byte %h status %0d is_data %b is_last %b",
                     $realtime, out_data_i[7:0], out_data_i[9:8], out_user_i, out_last_i);
        end else begin
          want = expected_words.pop_front();
          if (out_data_i[7:0] != want.data_byte || out_data_i[9:8] != want.status ||
              out_user_i != want.is_data || out_last_i != want.is_last ||
              out_data_i[MOutTdataW-1:10] != '0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("%0t: mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b pad %h",
                       $realtime, want.data_byte, want.status, want.is_data,
                       want.is_last, out_data_i[7:0], out_data_i[9:8], out_user_i,
                       out_last_i, out_data_i[MOutTdataW-1:10]);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_char(in_data_i, in_last_i);
      pending_o <= expected_words.size();
      fails_o   <= n_mismatch;
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of base64_decoder_whitespace_skip. A short directed run covers
// the alphabet ends, every whitespace code, padding in places 1, 3 and 4,
// bad characters and each closing status but after-pad. After it come random
// texts: mostly well formed, with whitespace, stray bytes, dropped characters
// and data after padding mixed in. Both sides idle in random bursts; the
// receiver holds off once for long enough to back the decoder up, and the
// sender waits for the output to drain. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned NumItems   = 220;
  localparam string       B64Chars   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0]  WsChars [6] = '{8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SInTdataW-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [MOutTdataW-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int unsigned n_pending;
  int unsigned n_fails;
  int unsigned n_cycles = 0;
  int unsigned n_items  = 0;
  logic        gaps_on;
  logic        stall_on;
  logic        long_hold;

  always #4 clk_i = ~clk_i;

  base64_decoder_whitespace_skip u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  b64d_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .pending_o   (n_pending),
    .fails_o     (n_fails)
  );

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // tvalid is left high after a word; whoever pauses the sender lowers it
  task automatic send_word(input logic [7:0] ch, input logic eot);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
  endtask

  task automatic send_text();
    logic [7:0] txt[$];
    int         nq;
    int         npad;
    int         i;
    nq = $urandom_range(0, 4);
    for (i = 0; i < 4 * nq; i++) txt.push_back(B64Chars[$urandom_range(0, 63)]);
    if (nq > 0) begin
      npad = $urandom_range(0, 2);
      for (i = 0; i < npad; i++) txt[txt.size() - 1 - i] = "=";
    end
    case ($urandom_range(0, 9))
      7: txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
      8: repeat ($urandom_range(1, 4))
           txt.push_back($urandom_range(0, 3) == 0 ? "=" : B64Chars[$urandom_range(0, 63)]);
      9: if (txt.size() != 0) txt.delete($urandom_range(0, txt.size() - 1));
      default: ;
    endcase
    foreach (txt[k]) begin
      if ($urandom_range(0, 7) == 0) send_word(WsChars[$urandom_range(0, 5)], 1'b0);
      send_word(txt[k], 1'b0);
      n_items++;
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
    n_items++;
  endtask

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (stall_on ? $urandom_range(1, 12) : 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [8:0] directed [26];
    logic       hold_done;
    logic       drained;
    directed = '{
      // alphabet ends and every whitespace code, plain quartets
      {1'b0, "/"}, {1'b0, 8'h20}, {1'b0, "+"}, {1'b0, 8'h0C}, {1'b0, "z"},
      {1'b0, "9"}, {1'b0, "A"}, {1'b0, 8'h0B}, {1'b0, "Z"}, {1'b0, "a"},
      {1'b0, 8'h09}, {1'b0, "0"}, {1'b1, 8'hFF},
      // two-byte quartet, then data after padding
      {1'b0, "T"}, {1'b0, "W"}, {1'b0, "E"}, {1'b0, "="}, {1'b0, "A"},
      {1'b0, 8'h0D}, {1'b0, "A"}, {1'b0, "A"}, {1'b0, 8'h0A}, {1'b1, 8'h00},
      // pad in first place, bad character beats bad count
      {1'b0, "="}, {1'b0, 8'hFF}, {1'b1, 8'h00}
    };
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    long_hold     = 1'b0;
    hold_done     = 1'b0;
    drained       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      send_word(directed[k][7:0], directed[k][8]);
      n_items++;
    end
    // third character padded: one byte only
    send_word("T", 1'b0);
    send_word("Q", 1'b0);
    send_word("=", 1'b0);
    send_word("=", 1'b0);
    send_word(8'h00, 1'b1);
    n_items += 5;

    while (n_items < NumItems) begin
      if (n_items > 90 && !hold_done) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (n_items > 140 && !drained) begin
        wait_drained();
        drained = 1'b1;
      end
      if (n_items > 180) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      send_text();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
